### rtl/p2f_pkg.sv
// Package with the types, constants and register codes of the parabolic-to-fisheye remap.
`default_nettype none
package p2f_pkg;

    // Number formats of the datapath.
    localparam int COORD_BITS   = 12;
    localparam int FRAC_BITS    = 8;
    localparam int CENTER_BITS  = COORD_BITS + FRAC_BITS;
    localparam int AX_BITS      = CENTER_BITS + 1;
    localparam int MP_BITS      = 24;
    localparam int QUO_BITS     = 26;
    localparam int DEN_BITS     = 83;
    localparam int NUM_BITS     = 87;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DAT_BITS = 24;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IMAGE_ROWS = 3'd0,
        CFG_IMAGE_COLS = 3'd1,
        CFG_CENTER_X   = 3'd2,
        CFG_CENTER_Y   = 3'd3,
        CFG_MIRROR_M   = 3'd4,
        CFG_MIRROR_L   = 3'd5
    } t_cfg_idx;

    // Input beat.
    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_col;
        logic [COORD_BITS-1:0] pixel_row;
    } t_pix_in;

    // Output beat.
    typedef struct packed {
        logic signed [23:0] fish_u;
        logic signed [23:0] fish_v;
        logic               valid_mask;
        logic               double_inside;
        logic [MP_BITS-1:0] para_scale;
    } t_fish_out;

    // Pixel data that rides along the mp division cells.
    typedef struct packed {
        logic               sx;
        logic               sy;
        logic [AX_BITS-1:0] ax;
        logic [AX_BITS-1:0] ay;
        logic               dbl;
    } t_mp_side;

    // Partial state of the mp division.
    typedef struct packed {
        logic               sat;
        logic [MP_BITS-1:0] rem;
        logic [MP_BITS-1:0] q;
    } t_mp_state;

    // Per-pixel flags that ride along the offset division cells.
    typedef struct packed {
        logic               sx;
        logic               sy;
        logic               mask;
        logic               dbl;
        logic [MP_BITS-1:0] mp;
        logic               cap_u;
        logic               cap_v;
        logic               zero_u;
        logic               zero_v;
    } t_div_side;

    // Partial state of the two offset divisions, which share one divisor.
    typedef struct packed {
        logic [DEN_BITS-1:0] den;
        logic [DEN_BITS-1:0] rem_u;
        logic [DEN_BITS-1:0] rem_v;
        logic [QUO_BITS-1:0] low_u;
        logic [QUO_BITS-1:0] low_v;
        logic [QUO_BITS-1:0] q_u;
        logic [QUO_BITS-1:0] q_v;
    } t_div_state;

endpackage
`default_nettype wire

### rtl/parabolic_to_fisheye_remap.sv
// Top level of the parabolic-to-fisheye remap: front end, cell chains, output stage.
// The block takes one pixel per clock and returns one result beat per pixel, in order,
// after the pixel has passed through one input stage, a chain of 24 cells that forms
// mp = m/l one quotient bit per cell, four multiply and add stages, a chain of 26 cells
// that forms both offsets one quotient bit per cell, a placement stage and the output
// register. A skid register behind the pipeline lets one more pixel in while a result
// waits on the output; input ready drops only while that skid register is full.
// Write registers while no pixel is in flight; unenforced. They act on the next pixel.
`default_nettype none
module parabolic_to_fisheye_remap (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  p2f_pkg::t_pix_in                      i_pix,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output p2f_pkg::t_fish_out                    o_fish,
    input  logic                                  i_cfg_we,
    input  logic [p2f_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [p2f_pkg::CFG_DAT_BITS-1:0]      i_cfg_data
);

    localparam int CB  = p2f_pkg::COORD_BITS;
    localparam int FB  = p2f_pkg::FRAC_BITS;
    localparam int ZB  = p2f_pkg::CENTER_BITS;
    localparam int AB  = p2f_pkg::AX_BITS;
    localparam int MB  = p2f_pkg::MP_BITS;
    localparam int QB  = p2f_pkg::QUO_BITS;
    localparam int DB  = p2f_pkg::DEN_BITS;
    localparam int NB  = p2f_pkg::NUM_BITS;
    localparam int XB  = ZB + 2;
    localparam int SQS = 32 - 2 * FB;

    // Configuration registers.
    logic [CB:0]   r_rows;
    logic [CB:0]   r_cols;
    logic [ZB-1:0] r_cx;
    logic [ZB-1:0] r_cy;
    logic [MB-1:0] r_m;
    logic [MB-1:0] r_l;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 13'd480;
            r_cols <= 13'd640;
            r_cx   <= 20'd81920;
            r_cy   <= 20'd61440;
            r_m    <= 24'd65536;
            r_l    <= 24'd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                p2f_pkg::CFG_IMAGE_ROWS: r_rows <= i_cfg_data[CB:0];
                p2f_pkg::CFG_IMAGE_COLS: r_cols <= i_cfg_data[CB:0];
                p2f_pkg::CFG_CENTER_X:   r_cx   <= i_cfg_data[ZB-1:0];
                p2f_pkg::CFG_CENTER_Y:   r_cy   <= i_cfg_data[ZB-1:0];
                p2f_pkg::CFG_MIRROR_M:   r_m    <= i_cfg_data[MB-1:0];
                p2f_pkg::CFG_MIRROR_L:   r_l    <= i_cfg_data[MB-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline moves while the skid register is empty.
    logic r_skid_v;
    logic w_en;
    assign w_en       = !r_skid_v;
    assign o_in_ready = w_en;

    // Input stage: offsets from the center, their signs and magnitudes, border flag.
    logic [CB:0]         w_col1;
    logic [CB:0]         w_row1;
    logic signed [XB-1:0] w_x;
    logic signed [XB-1:0] w_y;
    logic signed [XB-1:0] w_nx;
    logic signed [XB-1:0] w_ny;
    p2f_pkg::t_mp_side   n_s1_side;
    p2f_pkg::t_mp_side   r_s1_side;
    logic                r_s1_v;

    always_comb begin
        w_col1        = {1'b0, i_pix.pixel_col} + 13'd1;
        w_row1        = {1'b0, i_pix.pixel_row} + 13'd1;
        w_x           = $signed({1'b0, w_col1, {FB{1'b0}}}) - $signed({2'b0, r_cx});
        w_y           = $signed({1'b0, w_row1, {FB{1'b0}}}) - $signed({2'b0, r_cy});
        w_nx          = -w_x;
        w_ny          = -w_y;
        n_s1_side.sx  = w_x[XB-1];
        n_s1_side.sy  = w_y[XB-1];
        n_s1_side.ax  = w_x[XB-1] ? w_nx[AB-1:0] : w_x[AB-1:0];
        n_s1_side.ay  = w_y[XB-1] ? w_ny[AB-1:0] : w_y[AB-1:0];
        n_s1_side.dbl = (w_row1 < r_rows) && (w_col1 < r_cols);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_side <= n_s1_side;
        end
    end

    // Chain of cells for mp = floor(m * 2^16 / l), saturated.
    logic                w_mp_v    [0:MB];
    p2f_pkg::t_mp_side   w_mp_side [0:MB];
    p2f_pkg::t_mp_state  w_mp_st   [0:MB];
    logic                w_mp_bit  [0:MB-1];
    logic [MB-1:0]       w_mp;

    always_comb begin
        w_mp_v[0]      = r_s1_v;
        w_mp_side[0]   = r_s1_side;
        w_mp_st[0].sat = (r_l == '0) || ({8'b0, r_m} >= {r_l, 8'b0});
        w_mp_st[0].rem = {8'b0, r_m[MB-1:8]};
        w_mp_st[0].q   = '0;
    end

    for (genvar k = 0; k < MB; k++) begin : g_mp
        if (k < 8) begin : g_bit
            assign w_mp_bit[k] = r_m[7-k];
        end else begin : g_zero
            assign w_mp_bit[k] = 1'b0;
        end
        p2f_mp_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_valid   (w_mp_v[k]),
            .i_side    (w_mp_side[k]),
            .i_st      (w_mp_st[k]),
            .i_bit     (w_mp_bit[k]),
            .i_divisor (r_l),
            .o_valid   (w_mp_v[k+1]),
            .o_side    (w_mp_side[k+1]),
            .o_st      (w_mp_st[k+1])
        );
    end

    assign w_mp = w_mp_st[MB].sat ? '1 : w_mp_st[MB].q;

    // Stage one: D = 1 + mp, D^2 and the squared offsets.
    logic [MB:0]         n_p1_d;
    logic [2*MB+1:0]     n_p1_a;
    logic [2*AB-1:0]     n_p1_sqx;
    logic [2*AB-1:0]     n_p1_sqy;
    logic                r_p1_v;
    logic [MB:0]         r_p1_d;
    logic [2*MB+1:0]     r_p1_a;
    logic [2*AB-1:0]     r_p1_sqx;
    logic [2*AB-1:0]     r_p1_sqy;
    p2f_pkg::t_mp_side   r_p1_side;
    logic [MB-1:0]       r_p1_mp;

    always_comb begin
        n_p1_d   = 25'h10000 + {1'b0, w_mp};
        n_p1_a   = {{(MB+1){1'b0}}, n_p1_d} * {{(MB+1){1'b0}}, n_p1_d};
        n_p1_sqx = {{AB{1'b0}}, w_mp_side[MB].ax} * {{AB{1'b0}}, w_mp_side[MB].ax};
        n_p1_sqy = {{AB{1'b0}}, w_mp_side[MB].ay} * {{AB{1'b0}}, w_mp_side[MB].ay};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else if (w_en) begin
            r_p1_v <= w_mp_v[MB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_d    <= n_p1_d;
            r_p1_a    <= n_p1_a;
            r_p1_sqx  <= n_p1_sqx;
            r_p1_sqy  <= n_p1_sqy;
            r_p1_side <= w_mp_side[MB];
            r_p1_mp   <= w_mp;
        end
    end

    // Stage two: R^2, sum and difference with D^2, mask, and the offsets times 2D.
    logic [58:0]          w_b;
    logic [58:0]          w_a;
    logic [58:0]          n_p2_sum;
    logic [58:0]          n_p2_diff;
    logic [46:0]          n_p2_tu;
    logic [46:0]          n_p2_tv;
    p2f_pkg::t_div_side   n_p2_tail;
    logic                 r_p2_v;
    logic [58:0]          r_p2_sum;
    logic [58:0]          r_p2_diff;
    logic [46:0]          r_p2_tu;
    logic [46:0]          r_p2_tv;
    p2f_pkg::t_div_side   r_p2_tail;

    always_comb begin
        w_b              = {({1'b0, r_p1_sqx} + {1'b0, r_p1_sqy}), {SQS{1'b0}}};
        w_a              = {9'b0, r_p1_a};
        n_p2_sum         = w_a + w_b;
        n_p2_diff        = (w_b <= w_a) ? (w_a - w_b) : (w_b - w_a);
        n_p2_tu          = {26'b0, r_p1_side.ax} * {21'b0, r_p1_d, 1'b0};
        n_p2_tv          = {26'b0, r_p1_side.ay} * {21'b0, r_p1_d, 1'b0};
        n_p2_tail.sx     = r_p1_side.sx;
        n_p2_tail.sy     = r_p1_side.sy;
        n_p2_tail.mask   = (w_b <= w_a);
        n_p2_tail.dbl    = r_p1_side.dbl;
        n_p2_tail.mp     = r_p1_mp;
        n_p2_tail.cap_u  = 1'b0;
        n_p2_tail.cap_v  = 1'b0;
        n_p2_tail.zero_u = 1'b0;
        n_p2_tail.zero_v = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_v <= 1'b0;
        end else if (w_en) begin
            r_p2_v <= r_p1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p2_sum  <= n_p2_sum;
            r_p2_diff <= n_p2_diff;
            r_p2_tu   <= n_p2_tu;
            r_p2_tv   <= n_p2_tv;
            r_p2_tail <= n_p2_tail;
        end
    end

    // Stage three: partial products of l * sum and of the numerators times (l + m).
    logic [MB:0]          w_lm;
    logic [53:0]          n_p3_pl;
    logic [52:0]          n_p3_ph;
    logic [48:0]          n_p3_ul;
    logic [47:0]          n_p3_uh;
    logic [48:0]          n_p3_vl;
    logic [47:0]          n_p3_vh;
    logic                 r_p3_v;
    logic [53:0]          r_p3_pl;
    logic [52:0]          r_p3_ph;
    logic [58:0]          r_p3_diff;
    logic [48:0]          r_p3_ul;
    logic [47:0]          r_p3_uh;
    logic [48:0]          r_p3_vl;
    logic [47:0]          r_p3_vh;
    p2f_pkg::t_div_side   r_p3_tail;

    always_comb begin
        w_lm    = {1'b0, r_l} + {1'b0, r_m};
        n_p3_pl = {30'b0, r_l} * {24'b0, r_p2_sum[29:0]};
        n_p3_ph = {29'b0, r_l} * {24'b0, r_p2_sum[58:30]};
        n_p3_ul = {24'b0, r_p2_tu[23:0]} * {24'b0, w_lm};
        n_p3_uh = {25'b0, r_p2_tu[46:24]} * {23'b0, w_lm};
        n_p3_vl = {24'b0, r_p2_tv[23:0]} * {24'b0, w_lm};
        n_p3_vh = {25'b0, r_p2_tv[46:24]} * {23'b0, w_lm};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_v <= 1'b0;
        end else if (w_en) begin
            r_p3_v <= r_p2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p3_pl   <= n_p3_pl;
            r_p3_ph   <= n_p3_ph;
            r_p3_diff <= r_p2_diff;
            r_p3_ul   <= n_p3_ul;
            r_p3_uh   <= n_p3_uh;
            r_p3_vl   <= n_p3_vl;
            r_p3_vh   <= n_p3_vh;
            r_p3_tail <= r_p2_tail;
        end
    end

    // Stage four: divisor l*(D^2+R^2) + |D^2-R^2| * 2^16 and both numerators.
    logic [DB:0]          w_den;
    logic [71:0]          w_nu;
    logic [71:0]          w_nv;
    logic                 r_p4_v;
    logic [DB-1:0]        r_p4_den;
    logic [NB-1:0]        r_p4_num_u;
    logic [NB-1:0]        r_p4_num_v;
    p2f_pkg::t_div_side   r_p4_tail;

    always_comb begin
        w_den = {30'b0, r_p3_pl} + {1'b0, r_p3_ph, 30'b0} + {9'b0, r_p3_diff, 16'b0};
        w_nu  = {23'b0, r_p3_ul} + {r_p3_uh, 24'b0};
        w_nv  = {23'b0, r_p3_vl} + {r_p3_vh, 24'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_v <= 1'b0;
        end else if (w_en) begin
            r_p4_v <= r_p3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p4_den   <= w_den[DB-1:0];
            r_p4_num_u <= {w_nu[70:0], 16'b0};
            r_p4_num_v <= {w_nv[70:0], 16'b0};
            r_p4_tail  <= r_p3_tail;
        end
    end

    // Chain of cells for both offsets, quotient capped at 2^26.
    logic                 w_dv_v    [0:QB];
    p2f_pkg::t_div_side   w_dv_side [0:QB];
    p2f_pkg::t_div_state  w_dv_st   [0:QB];

    always_comb begin
        w_dv_v[0]           = r_p4_v;
        w_dv_side[0]        = r_p4_tail;
        w_dv_side[0].zero_u = (r_p4_num_u == '0);
        w_dv_side[0].zero_v = (r_p4_num_v == '0);
        w_dv_side[0].cap_u  = (r_p4_num_u != '0)
                              && ({22'b0, r_p4_num_u} >= {r_p4_den, {QB{1'b0}}});
        w_dv_side[0].cap_v  = (r_p4_num_v != '0)
                              && ({22'b0, r_p4_num_v} >= {r_p4_den, {QB{1'b0}}});
        w_dv_st[0].den      = r_p4_den;
        w_dv_st[0].rem_u    = {22'b0, r_p4_num_u[NB-1:QB]};
        w_dv_st[0].rem_v    = {22'b0, r_p4_num_v[NB-1:QB]};
        w_dv_st[0].low_u    = r_p4_num_u[QB-1:0];
        w_dv_st[0].low_v    = r_p4_num_v[QB-1:0];
        w_dv_st[0].q_u      = '0;
        w_dv_st[0].q_v      = '0;
    end

    for (genvar k = 0; k < QB; k++) begin : g_div
        p2f_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv_v[k]),
            .i_side  (w_dv_side[k]),
            .i_st    (w_dv_st[k]),
            .o_valid (w_dv_v[k+1]),
            .o_side  (w_dv_side[k+1]),
            .o_st    (w_dv_st[k+1])
        );
    end

    // Add the signed offset to the center and saturate to Q15.8.
    function automatic logic [23:0] place(input logic [ZB-1:0] c, input logic s,
                                          input logic cap, input logic zero,
                                          input logic [QB-1:0] q);
        logic [QB:0]        qq;
        logic signed [28:0] v;
        logic [23:0]        r;
        qq = cap ? {1'b1, {QB{1'b0}}} : (zero ? '0 : {1'b0, q});
        if (s) begin
            v = $signed({9'b0, c}) - $signed({2'b0, qq});
        end else begin
            v = $signed({9'b0, c}) + $signed({2'b0, qq});
        end
        if (v > 29'sd8388607) begin
            r = 24'h7FFFFF;
        end else if (v < -29'sd8388608) begin
            r = 24'h800000;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    // Placement stage.
    p2f_pkg::t_fish_out n_f;
    p2f_pkg::t_fish_out r_f;
    logic               r_f_v;

    always_comb begin
        n_f.fish_u        = place(r_cx, w_dv_side[QB].sx, w_dv_side[QB].cap_u,
                                  w_dv_side[QB].zero_u, w_dv_st[QB].q_u);
        n_f.fish_v        = place(r_cy, w_dv_side[QB].sy, w_dv_side[QB].cap_v,
                                  w_dv_side[QB].zero_v, w_dv_st[QB].q_v);
        n_f.valid_mask    = w_dv_side[QB].mask;
        n_f.double_inside = w_dv_side[QB].dbl;
        n_f.para_scale    = w_dv_side[QB].mp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (w_en) begin
            r_f_v <= w_dv_v[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f <= n_f;
        end
    end

    // Output register with a skid register behind it.
    p2f_pkg::t_fish_out r_out;
    p2f_pkg::t_fish_out r_skid;
    logic               r_out_v;
    logic               w_out_free;

    assign w_out_free = !r_out_v || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= r_f_v;
            end
        end else if (r_f_v && w_en) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_skid_v ? r_skid : r_f;
        end
        if (!r_skid_v) begin
            r_skid <= r_f;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_fish      = r_out;

`ifndef NO_ASSERTIONS
    // The skid register fills only behind a waiting output beat.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register holds a beat while the output is empty");

    // A held skid beat stays until the output moves.
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !i_out_ready) |=> r_skid_v)
        else $error("skid beat lost while the output was stalled");

    // A result reaching a stalled full output lands in the skid register.
    a_skid_catches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_out_ready && r_f_v && !r_skid_v) |=> r_skid_v)
        else $error("result dropped at a stalled output");

    // With nothing behind it, a taken output beat leaves the output empty.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && i_out_ready && !r_skid_v && !r_f_v) |=> !r_out_v)
        else $error("output beat repeated");
`endif

endmodule
`default_nettype wire

### rtl/p2f_mp_cell.sv
// One restoring step of the mp = m/l division, with the pixel data carried along.
`default_nettype none
module p2f_mp_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  p2f_pkg::t_mp_side                 i_side,
    input  p2f_pkg::t_mp_state                i_st,
    input  logic                              i_bit,
    input  logic [p2f_pkg::MP_BITS-1:0]       i_divisor,
    output logic                              o_valid,
    output p2f_pkg::t_mp_side                 o_side,
    output p2f_pkg::t_mp_state                o_st
);

    logic                        r_valid;
    p2f_pkg::t_mp_side           r_side;
    p2f_pkg::t_mp_state          r_st;
    p2f_pkg::t_mp_state          n_st;
    logic [p2f_pkg::MP_BITS:0]   w_rem2;
    logic [p2f_pkg::MP_BITS:0]   w_sub;
    logic                        w_ge;

    // Shift in the next dividend bit and subtract the divisor when it fits.
    always_comb begin
        w_rem2   = {i_st.rem, i_bit};
        w_sub    = w_rem2 - {1'b0, i_divisor};
        w_ge     = (w_rem2 >= {1'b0, i_divisor});
        n_st.sat = i_st.sat;
        n_st.rem = w_ge ? w_sub[p2f_pkg::MP_BITS-1:0] : w_rem2[p2f_pkg::MP_BITS-1:0];
        n_st.q   = {i_st.q[p2f_pkg::MP_BITS-2:0], w_ge};
    end

    // Valid bit of this cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Payload of this cell.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_st   <= n_st;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_st    = r_st;

endmodule
`default_nettype wire

### rtl/p2f_div_cell.sv
// One restoring step of both offset divisions, sharing the divisor of the pixel.
`default_nettype none
module p2f_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  p2f_pkg::t_div_side  i_side,
    input  p2f_pkg::t_div_state i_st,
    output logic                o_valid,
    output p2f_pkg::t_div_side  o_side,
    output p2f_pkg::t_div_state o_st
);

    localparam int DB = p2f_pkg::DEN_BITS;
    localparam int QB = p2f_pkg::QUO_BITS;

    logic                r_valid;
    p2f_pkg::t_div_side  r_side;
    p2f_pkg::t_div_state r_st;
    p2f_pkg::t_div_state n_st;
    logic [DB:0]         w_rem2_u;
    logic [DB:0]         w_rem2_v;
    logic [DB:0]         w_sub_u;
    logic [DB:0]         w_sub_v;
    logic                w_ge_u;
    logic                w_ge_v;

    // Bring down the next numerator bit of each lane and subtract where it fits.
    always_comb begin
        w_rem2_u   = {i_st.rem_u, i_st.low_u[QB-1]};
        w_rem2_v   = {i_st.rem_v, i_st.low_v[QB-1]};
        w_sub_u    = w_rem2_u - {1'b0, i_st.den};
        w_sub_v    = w_rem2_v - {1'b0, i_st.den};
        w_ge_u     = (w_rem2_u >= {1'b0, i_st.den});
        w_ge_v     = (w_rem2_v >= {1'b0, i_st.den});
        n_st.den   = i_st.den;
        n_st.rem_u = w_ge_u ? w_sub_u[DB-1:0] : w_rem2_u[DB-1:0];
        n_st.rem_v = w_ge_v ? w_sub_v[DB-1:0] : w_rem2_v[DB-1:0];
        n_st.low_u = {i_st.low_u[QB-2:0], 1'b0};
        n_st.low_v = {i_st.low_v[QB-2:0], 1'b0};
        n_st.q_u   = {i_st.q_u[QB-2:0], w_ge_u};
        n_st.q_v   = {i_st.q_v[QB-2:0], w_ge_v};
    end

    // Valid bit of this cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Payload of this cell.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_st   <= n_st;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_st    = r_st;

endmodule
`default_nettype wire

### bench/p2f_remap_checker.sv
// Checker that predicts every fisheye result beat of the remap and compares it with the block.
`timescale 1ns / 100ps
module p2f_remap_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  p2f_pkg::t_pix_in                 i_pix,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  p2f_pkg::t_fish_out               i_fish,
    input  logic                             i_cfg_we,
    input  logic [p2f_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [p2f_pkg::CFG_DAT_BITS-1:0] i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);

    localparam logic [127:0] OFFSET_CAP = 128'd1 << 26;
    localparam longint       FISH_MAX   = 8388607;
    localparam longint       FISH_MIN   = -8388608;

    // Shadow copy of the configuration registers.
    logic [12:0] rows_q, cols_q;
    logic [19:0] cx_q, cy_q;
    logic [23:0] m_q, l_q;

    p2f_pkg::t_fish_out expected_fish[$];

    // One fisheye coordinate: center plus the signed, truncated and capped offset.
    function automatic logic [23:0] place_coord(longint center, longint delta,
                                                logic [127:0] den, longint unsigned twod,
                                                longint unsigned lm);
        logic [127:0] mag, num, quo;
        longint       v;
        mag = (delta < 0) ? 128'(-delta) : 128'(delta);
        num = ((mag * 128'(twod)) * 128'(lm)) << 16;
        if (den == 0) begin
            quo = (num == 0) ? 128'd0 : OFFSET_CAP;
        end else begin
            quo = num / den;
            if (quo > OFFSET_CAP) quo = OFFSET_CAP;
        end
        v = center + ((delta < 0) ? -longint'(quo) : longint'(quo));
        if (v > FISH_MAX) v = FISH_MAX;
        if (v < FISH_MIN) v = FISH_MIN;
        return v[23:0];
    endfunction

    // Full prediction for one pixel under the current registers.
    function automatic p2f_pkg::t_fish_out remap_pixel(p2f_pkg::t_pix_in p);
        longint             x, y;
        longint unsigned    ax, ay, mp, d, a, b, diff, lm;
        logic [127:0]       den;
        p2f_pkg::t_fish_out r;
        x  = (longint'(p.pixel_col) + 1) * 256 - longint'(cx_q);
        y  = (longint'(p.pixel_row) + 1) * 256 - longint'(cy_q);
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        if (l_q == 0) begin
            mp = 64'hFFFFFF;
        end else begin
            mp = (longint'(m_q) << 16) / longint'(l_q);
            if (mp > 64'hFFFFFF) mp = 64'hFFFFFF;
        end
        d    = 65536 + mp;
        a    = d * d;
        b    = (ax * ax + ay * ay) << 16;
        diff = (a >= b) ? a - b : b - a;
        den  = 128'(l_q) * 128'(a + b) + (128'(diff) << 16);
        lm   = longint'(l_q) + longint'(m_q);
        r.fish_u        = place_coord(longint'(cx_q), x, den, 2 * d, lm);
        r.fish_v        = place_coord(longint'(cy_q), y, den, 2 * d, lm);
        r.valid_mask    = (b <= a);
        r.double_inside = (32'(p.pixel_row) + 1 < 32'(rows_q)) &&
                          (32'(p.pixel_col) + 1 < 32'(cols_q));
        r.para_scale    = mp[23:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [23:0] exp_val, logic [23:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
            o_fail_count++;
        end
    endtask

    initial o_fail_count = 0;
    initial o_pending = 0;

    // Track registers, queue predictions on input beats, compare on output beats.
    always @(posedge i_clk) begin
        p2f_pkg::t_fish_out want;
        if (!i_rst_n) begin
            rows_q = 13'd480;
            cols_q = 13'd640;
            cx_q   = 20'd81920;
            cy_q   = 20'd61440;
            m_q    = 24'd65536;
            l_q    = 24'd65536;
            expected_fish.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    p2f_pkg::CFG_IMAGE_ROWS: rows_q = i_cfg_data[12:0];
                    p2f_pkg::CFG_IMAGE_COLS: cols_q = i_cfg_data[12:0];
                    p2f_pkg::CFG_CENTER_X:   cx_q   = i_cfg_data[19:0];
                    p2f_pkg::CFG_CENTER_Y:   cy_q   = i_cfg_data[19:0];
                    p2f_pkg::CFG_MIRROR_M:   m_q    = i_cfg_data;
                    p2f_pkg::CFG_MIRROR_L:   l_q    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_fish.size() == 0) begin
                    $error("result beat with no pixel outstanding");
                    o_fail_count++;
                end else begin
                    want = expected_fish.pop_front();
                    check_field("fish_u", want.fish_u, i_fish.fish_u);
                    check_field("fish_v", want.fish_v, i_fish.fish_v);
                    check_field("valid_mask", 24'(want.valid_mask), 24'(i_fish.valid_mask));
                    check_field("double_inside", 24'(want.double_inside),
                                24'(i_fish.double_inside));
                    check_field("para_scale", want.para_scale, i_fish.para_scale);
                end
            end
            if (i_in_valid && i_in_ready) expected_fish.push_back(remap_pixel(i_pix));
        end
        o_pending = expected_fish.size();
    end

endmodule

### bench/tb_parabolic_to_fisheye_remap.sv
// Testbench top for the parabolic-to-fisheye remap: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb_parabolic_to_fisheye_remap;

    localparam int CYCLE_LIMIT = 300000;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_ready;
    p2f_pkg::t_pix_in                 i_pix = '0;
    logic                             o_out_valid;
    logic                             i_out_ready = 1'b0;
    p2f_pkg::t_fish_out               o_fish;
    logic                             i_cfg_we = 1'b0;
    logic [p2f_pkg::CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [p2f_pkg::CFG_DAT_BITS-1:0] i_cfg_data = '0;

    int fail_count;
    int pending_pixels;
    int cycle_count = 0;
    int beats_taken = 0;
    bit no_gaps = 1'b0;

    parabolic_to_fisheye_remap dut (.*);

    p2f_remap_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_pix(i_pix),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_fish(o_fish),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending_pixels)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int draw_wait();
        return no_gaps ? 0 : $urandom_range(0, 7);
    endfunction

    // Result side: random stalls per beat, plus one long hold-off to back up the pipeline.
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = (beats_taken == 150) ? 1000 : draw_wait();
            if (stall > 0) begin
                @(negedge i_clk) i_out_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk) i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            beats_taken++;
        end
    end

    task automatic send_pixel(int col, int row);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_pix      <= '{pixel_col: col[11:0], pixel_row: row[11:0]};
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_reg(p2f_pkg::t_cfg_idx idx, int value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[23:0];
        @(negedge i_clk) i_cfg_we <= 1'b0;
    endtask

    // Lower valid and let the pipeline drain before touching the registers.
    task automatic drain();
        @(negedge i_clk) i_in_valid <= 1'b0;
        wait (pending_pixels == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_setting(int rows, int cols, int cx, int cy, int m, int l);
        write_reg(p2f_pkg::CFG_IMAGE_ROWS, rows);
        write_reg(p2f_pkg::CFG_IMAGE_COLS, cols);
        write_reg(p2f_pkg::CFG_CENTER_X, cx);
        write_reg(p2f_pkg::CFG_CENTER_Y, cy);
        write_reg(p2f_pkg::CFG_MIRROR_M, m);
        write_reg(p2f_pkg::CFG_MIRROR_L, l);
    endtask

    // Random pixels: a mix of the full raster and a window around the center, where the
    // fold boundary lives.
    task automatic random_pixels(int count, int cx, int cy);
        int col, row;
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) == 0) begin
                col = $urandom_range(0, 4095);
                row = $urandom_range(0, 4095);
            end else begin
                col = (cx >> 8) + $urandom_range(0, 128) - 64;
                row = (cy >> 8) + $urandom_range(0, 128) - 64;
                col = (col < 0) ? 0 : (col > 4095) ? 4095 : col;
                row = (row < 0) ? 0 : (row > 4095) ? 4095 : row;
            end
            send_pixel(col, row);
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        int cx, cy;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Reset registers: raster corners, the exact center, and both sides of the fold.
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(0, 4095);
        send_pixel(4095, 0);
        send_pixel(319, 239);
        send_pixel(321, 239);
        send_pixel(322, 239);
        send_pixel(319, 241);
        send_pixel(319, 242);
        send_pixel(638, 478);
        send_pixel(639, 479);
        random_pixels(290, 81920, 61440);
        drain();

        // Smallest image, center at the origin, m of zero.
        load_setting(2, 2, 0, 0, 0, 1);
        send_pixel(0, 0);
        send_pixel(1, 0);
        send_pixel(0, 1);
        send_pixel(4095, 4095);
        random_pixels(290, 0, 0);
        drain();

        // Largest image and center, largest model parameters.
        load_setting(4096, 4096, 20'hFFFFF, 20'hFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_pixel(4095, 4095);
        send_pixel(4094, 4094);
        send_pixel(0, 0);
        random_pixels(290, 20'hFFFFF, 20'hFFFFF);
        drain();

        // Zero l saturates mp; image sizes below two; huge m against tiny l.
        load_setting(1, 0, 81920, 61440, 24'h123456, 0);
        send_pixel(319, 239);
        send_pixel(0, 0);
        random_pixels(140, 81920, 61440);
        drain();
        load_setting(8191, 3, 4096, 0, 24'hFFFFFF, 1);
        send_pixel(1, 0);
        send_pixel(4095, 0);
        random_pixels(150, 4096, 0);
        drain();

        // Random settings.
        for (int s = 0; s < 3; s++) begin
            cx = $urandom_range(0, 20'hFFFFF);
            cy = $urandom_range(0, 20'hFFFFF);
            load_setting($urandom_range(0, 8191), $urandom_range(0, 8191), cx, cy,
                         $urandom_range(0, 24'hFFFFFF), $urandom_range(1, 24'hFFFFFF));
            random_pixels(200, cx, cy);
            drain();
        end

        repeat (80) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
